@@ rtl/core/bstl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_pkg - shared types and constants of the byte stream token lexer
// Token layout, run classes, character codes and the keyword spelling.
// ----------------------------------------------------------------------------
package bstl_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_W       = VALUE_WIDTH - 1;
    localparam int LEN_W       = 6;

    localparam logic [NUM_W-1:0] VAL_MAX  = '1;
    localparam logic [LEN_W-1:0] WORD_MAX = '1;

    // token queue
    localparam int FIFO_DEPTH = 4;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // keyword match progress: letters of the keyword matched, or a mismatch
    localparam logic [2:0] MATCH_NONE = 3'd0;
    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd7;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        TK_INTEGER  = 3'd0,
        TK_EXIT     = 3'd1,
        TK_OPEN     = 3'd2,
        TK_CLOSE    = 3'd3,
        TK_SEMI     = 3'd4,
        TK_BAD_WORD = 3'd5,
        TK_BAD_SEP  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        RUN_IDLE   = 2'd0,
        RUN_NUMBER = 2'd1,
        RUN_WORD   = 2'd2
    } t_run;

    typedef struct packed {
        t_kind              kind;
        logic [NUM_W-1:0]   value;
        logic               ovf;
        logic [LEN_W-1:0]   len;
        logic [7:0]         bad;
        logic               last;
    } t_token;

    // up to two tokens written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h65; // e
            2'd1:    c = 8'h78; // x
            2'd2:    c = 8'h69; // i
            2'd3:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/bstl_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_scan - input register, run state and token generation
// Classifies one byte per cycle while the token queue has room, updates the
// pending run and emits the zero, one or two tokens that the byte causes.
// ----------------------------------------------------------------------------
module bstl_scan import bstl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    input  wire logic        i_room,
    output t_push            o_push
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eot;

    t_run             r_run,   n_run;
    logic [NUM_W-1:0] r_acc,   n_acc;
    logic             r_sat,   n_sat;
    logic [2:0]       r_match, n_match;
    logic [LEN_W-1:0] r_len,   n_len;

    logic             consume, load;
    logic             is_digit, is_letter, is_space, is_other;
    logic             flush1, flush2;
    t_run             b_run, s_run;
    logic [NUM_W-1:0] b_acc, s_acc;
    logic             b_sat, s_sat;
    logic [2:0]       b_match, s_match;
    logic [LEN_W-1:0] b_len, s_len;
    logic [NUM_W+3:0] wide;
    t_token           tok_a, tok_s, tok_f;
    t_token           tok0, tok1;
    logic [1:0]       cnt;

    function automatic t_token run_token(input t_run run, input logic [NUM_W-1:0] acc,
                                         input logic sat, input logic [2:0] match,
                                         input logic [LEN_W-1:0] len);
        t_token t;
        t = '0;
        if (run == RUN_NUMBER) begin
            t.kind  = TK_INTEGER;
            t.value = acc;
            t.ovf   = sat;
        end else if (match == MATCH_FULL) begin
            t.kind = TK_EXIT;
        end else begin
            t.kind = TK_BAD_WORD;
            t.len  = len;
        end
        return t;
    endfunction

    assign consume = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
        if (load) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= RUN_IDLE;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_match <= MATCH_NONE;
            r_len   <= '0;
        end else if (consume) begin
            r_run   <= n_run;
            r_acc   <= n_acc;
            r_sat   <= n_sat;
            r_match <= n_match;
            r_len   <= n_len;
        end
    end

    always_comb begin
        is_digit  = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
        is_letter = ((r_in_byte >= CH_UC_A) && (r_in_byte <= CH_UC_Z)) ||
                    ((r_in_byte >= CH_LC_A) && (r_in_byte <= CH_LC_Z));
        is_space  = (r_in_byte == CH_SPACE) ||
                    ((r_in_byte >= CH_TAB) && (r_in_byte <= CH_CR));
        is_other  = !is_digit && !is_letter && !is_space;

        // a run ends when a byte of another class arrives
        flush1 = (r_run != RUN_IDLE) &&
                 !((r_run == RUN_NUMBER) && is_digit) &&
                 !((r_run == RUN_WORD) && is_letter);
        tok_a  = run_token(r_run, r_acc, r_sat, r_match, r_len);

        b_run   = flush1 ? RUN_IDLE   : r_run;
        b_acc   = flush1 ? '0         : r_acc;
        b_sat   = flush1 ? 1'b0       : r_sat;
        b_match = flush1 ? MATCH_NONE : r_match;
        b_len   = flush1 ? '0         : r_len;

        s_run   = b_run;
        s_acc   = b_acc;
        s_sat   = b_sat;
        s_match = b_match;
        s_len   = b_len;

        // acc * 10 + digit, compared against the saturation limit
        wide = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1) +
               {{NUM_W{1'b0}}, r_in_byte[3:0]};

        tok_s = '0;
        if (is_digit) begin
            s_run = RUN_NUMBER;
            if (b_sat || (wide > {4'b0, VAL_MAX})) begin
                s_acc = VAL_MAX;
                s_sat = 1'b1;
            end else begin
                s_acc = wide[NUM_W-1:0];
            end
        end else if (is_letter) begin
            s_run = RUN_WORD;
            if ((b_match < MATCH_FULL) && (kw_char(b_match[1:0]) == r_in_byte)) begin
                s_match = b_match + 3'd1;
            end else begin
                s_match = MATCH_FAIL;
            end
            if (b_len != WORD_MAX) begin
                s_len = b_len + LEN_W'(1);
            end
        end else if (is_other) begin
            if (r_in_byte == CH_OPEN) begin
                tok_s.kind = TK_OPEN;
            end else if (r_in_byte == CH_CLOSE) begin
                tok_s.kind = TK_CLOSE;
            end else if (r_in_byte == CH_SEMI) begin
                tok_s.kind = TK_SEMI;
            end else begin
                tok_s.kind = TK_BAD_SEP;
                tok_s.bad  = r_in_byte;
            end
        end

        flush2 = r_in_eot && (s_run != RUN_IDLE);
        tok_f  = run_token(s_run, s_acc, s_sat, s_match, s_len);

        n_run   = flush2 ? RUN_IDLE   : s_run;
        n_acc   = flush2 ? '0         : s_acc;
        n_sat   = flush2 ? 1'b0       : s_sat;
        n_match = flush2 ? MATCH_NONE : s_match;
        n_len   = flush2 ? '0         : s_len;

        // a separator leaves no run, so at most two of the three tokens exist
        cnt  = {1'b0, flush1} + {1'b0, is_other} + {1'b0, flush2};
        tok0 = flush1 ? tok_a : (is_other ? tok_s : tok_f);
        tok1 = (flush1 && is_other) ? tok_s : tok_f;
        tok0.last = (cnt == 2'd1);
        tok1.last = 1'b1;

        o_push.cnt  = consume ? cnt : 2'd0;
        o_push.tok0 = tok0;
        o_push.tok1 = tok1;
    end

endmodule
`default_nettype wire

@@ rtl/core/bstl_tok_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_tok_fifo - token queue
// Takes up to two tokens per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module bstl_tok_fifo import bstl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output logic        o_room,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_token      o_tok
);

    t_token            r_mem [FIFO_DEPTH];
    logic [ADDR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0]  r_count;
    logic              pop;

    // room for two more tokens, whatever the output side does this cycle
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_head];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (pop) begin
                r_head <= r_head + ADDR_W'(1);
            end
            r_tail  <= r_tail + ADDR_W'(i_push.cnt);
            r_count <= r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_tail] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_tail + ADDR_W'(1)] <= i_push.tok1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/byte_stream_token_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_token_lexer - text byte to token lexer
// Integers, the exit keyword, separators and error tokens from a byte stream.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  i_text_byte, i_end_of_text
//   tokens    out        o_valid / i_stall  o_token_kind .. o_last_of_run
//
// One byte is accepted per cycle unless o_stall is high; its tokens go through
// the input register and then the token queue. A byte that yields two tokens
// needs two output transfers. The four-entry token queue holds the input when
// more than two entries are in use, so a token-side stall reaches o_stall once it fills.
// i_rst_n is synchronous and clears the pending run and the queue.
// ----------------------------------------------------------------------------
module byte_stream_token_lexer import bstl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_text_byte,
    input  wire logic             i_end_of_text,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [2:0]            o_token_kind,
    output logic [NUM_W-1:0]      o_number_value,
    output logic                  o_number_overflow,
    output logic [LEN_W-1:0]      o_word_length,
    output logic [7:0]            o_bad_byte,
    output logic                  o_last_of_run
);

    t_push  push;
    t_token tok;
    logic   room;

    bstl_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_room        (room),
        .o_push        (push)
    );

    bstl_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (tok)
    );

    assign o_token_kind      = tok.kind;
    assign o_number_value    = tok.value;
    assign o_number_overflow = tok.ovf;
    assign o_word_length     = tok.len;
    assign o_bad_byte        = tok.bad;
    assign o_last_of_run     = tok.last;

endmodule
`default_nettype wire

@@ rtl/core/bstl_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_checker - port level checks of the lexer
// Token field consistency, reset behavior and output hold under stall.
// ----------------------------------------------------------------------------
module bstl_checker import bstl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_stall,
    input  wire logic             o_valid,
    input  wire logic             i_stall,
    input  wire logic [2:0]       o_token_kind,
    input  wire logic [NUM_W-1:0] o_number_value,
    input  wire logic             o_number_overflow,
    input  wire logic [LEN_W-1:0] o_word_length,
    input  wire logic [7:0]       o_bad_byte,
    input  wire logic             o_last_of_run
);

    // hold a stalled token
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
            $stable(o_number_value) && $stable(o_word_length) &&
            $stable(o_bad_byte) && $stable(o_last_of_run))
        else $error("token changed while stalled");

    a_num_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind != TK_INTEGER) |->
            (o_number_value == '0) && !o_number_overflow)
        else $error("number fields set on a non-integer token");

    a_other_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_word_length == '0) || (o_token_kind == TK_BAD_WORD)) &&
            ((o_bad_byte == 8'h00) || (o_token_kind == TK_BAD_SEP)))
        else $error("length or byte field set on the wrong token kind");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_number_overflow |-> (o_number_value == VAL_MAX))
        else $error("overflow flag without saturated value");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("lexer not empty after reset");

endmodule

bind byte_stream_token_lexer bstl_checker u_chk (.*);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench of the byte stream token lexer
// Feeds text bytes through the valid/stall input channel, predicts the token
// stream in a behavioral lexer and compares every token transfer field by
// field. Directed text first, then random well-formed text mixed with noise
// under several idle patterns, and one long token-side hold-off.
// ----------------------------------------------------------------------------
module tb;
    import bstl_pkg::*;

    localparam int  DRAIN_CYCLES = 20;
    localparam time TIMEOUT_NS   = 2_000_000;

    typedef enum logic [1:0] {
        BC_DIGIT  = 2'd0,
        BC_LETTER = 2'd1,
        BC_SPACE  = 2'd2,
        BC_OTHER  = 2'd3
    } t_byte_class;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_text_byte;
    logic             i_end_of_text;
    logic             o_valid;
    logic             i_stall;
    logic [2:0]       o_token_kind;
    logic [NUM_W-1:0] o_number_value;
    logic             o_number_overflow;
    logic [LEN_W-1:0] o_word_length;
    logic [7:0]       o_bad_byte;
    logic             o_last_of_run;

    byte_stream_token_lexer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_token_kind      (o_token_kind),
        .o_number_value    (o_number_value),
        .o_number_overflow (o_number_overflow),
        .o_word_length     (o_word_length),
        .o_bad_byte        (o_bad_byte),
        .o_last_of_run     (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // behavioral lexer state
    t_run             lex_run;
    logic [NUM_W-1:0] lex_value;
    logic             lex_sat;
    logic [2:0]       lex_match;
    logic [LEN_W-1:0] lex_letters;

    logic [7:0] exit_spelling [4] = '{8'h65, 8'h78, 8'h69, 8'h74};
    logic [7:0] space_bytes [6]   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    t_token step_tokens[$];
    t_token expected_tokens[$];

    int errors        = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    function automatic t_byte_class byte_class(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE)
            return BC_DIGIT;
        if ((b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z))
            return BC_LETTER;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
            return BC_SPACE;
        return BC_OTHER;
    endfunction

    function automatic t_token make_token(input t_kind kind, input logic [NUM_W-1:0] value,
                                          input logic ovf, input logic [LEN_W-1:0] len,
                                          input logic [7:0] bad);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.ovf   = ovf;
        t.len   = len;
        t.bad   = bad;
        t.last  = 1'b0;
        return t;
    endfunction

    // emit the pending run, if any, and return to idle
    task automatic flush_run();
        if (lex_run == RUN_NUMBER)
            step_tokens.push_back(make_token(TK_INTEGER, lex_value, lex_sat, '0, '0));
        else if (lex_run == RUN_WORD) begin
            if (lex_match == MATCH_FULL)
                step_tokens.push_back(make_token(TK_EXIT, '0, 1'b0, '0, '0));
            else
                step_tokens.push_back(make_token(TK_BAD_WORD, '0, 1'b0, lex_letters, '0));
        end
        lex_run     = RUN_IDLE;
        lex_value   = '0;
        lex_sat     = 1'b0;
        lex_match   = MATCH_NONE;
        lex_letters = '0;
    endtask

    task automatic predict_tokens(input logic [7:0] b, input logic eot);
        t_byte_class     cls;
        longint unsigned digit;
        longint unsigned vmax;
        cls  = byte_class(b);
        vmax = longint'(VAL_MAX);
        step_tokens.delete();
        if ((lex_run == RUN_NUMBER && cls != BC_DIGIT) ||
            (lex_run == RUN_WORD && cls != BC_LETTER))
            flush_run();
        case (cls)
            BC_DIGIT: begin
                digit   = longint'(b - CH_ZERO);
                lex_run = RUN_NUMBER;
                if (lex_sat || longint'(lex_value) > (vmax - digit) / 10) begin
                    lex_value = VAL_MAX;
                    lex_sat   = 1'b1;
                end else begin
                    lex_value = NUM_W'(longint'(lex_value) * 10 + digit);
                end
            end
            BC_LETTER: begin
                lex_run = RUN_WORD;
                if (lex_match < MATCH_FULL && exit_spelling[lex_match[1:0]] == b)
                    lex_match = lex_match + 3'd1;
                else
                    lex_match = MATCH_FAIL;
                if (lex_letters != WORD_MAX)
                    lex_letters = lex_letters + 1'b1;
            end
            BC_OTHER: begin
                if (b == CH_OPEN)
                    step_tokens.push_back(make_token(TK_OPEN, '0, 1'b0, '0, '0));
                else if (b == CH_CLOSE)
                    step_tokens.push_back(make_token(TK_CLOSE, '0, 1'b0, '0, '0));
                else if (b == CH_SEMI)
                    step_tokens.push_back(make_token(TK_SEMI, '0, 1'b0, '0, '0));
                else
                    step_tokens.push_back(make_token(TK_BAD_SEP, '0, 1'b0, '0, b));
            end
            default: ;
        endcase
        if (eot)
            flush_run();
        if (step_tokens.size() > 0)
            step_tokens[$].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // offer one byte, hold it until the transfer, then record its tokens
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        predict_tokens(b, eot);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    function automatic logic rand_eot();
        return $urandom_range(99) < 3;
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? CH_UC_A + 8'(r) : CH_LC_A + 8'(r - 26);
    endfunction

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_separators();
        send_text("();", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_keywords();
        // a run flushed by a separator gives two tokens on one byte
        send_text("exit;", 1'b0);
        send_text("Exit", 1'b1);
    endtask

    task automatic test_numbers();
        // digit run flushed by a letter, then the word flushed by end of text
        send_text("07a", 1'b1);
        // end of text with nothing pending
        send_byte(CH_SPACE, 1'b1);
    endtask

    task automatic send_random_number();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 4)
            send_text("2147483647", rand_eot());
        else if (r < 8)
            send_text("2147483648", rand_eot());
        else begin
            len = (r < 70) ? $urandom_range(1, 4) :
                  (r < 90) ? $urandom_range(5, 9) : $urandom_range(10, 12);
            for (int i = 0; i < len; i++)
                send_byte(CH_ZERO + 8'($urandom_range(9)), rand_eot());
        end
    endtask

    task automatic send_random_word();
        int r;
        int len;
        logic [7:0] w [$];
        r = $urandom_range(99);
        w.delete();
        foreach (exit_spelling[i])
            w.push_back(exit_spelling[i]);
        if (r < 35) begin
            // keep the keyword as it is
        end else if (r < 55)
            w[$urandom_range(3)] = rand_letter();
        else if (r < 65)
            w = w[0:$urandom_range(2)];
        else if (r < 72)
            w.push_back(rand_letter());
        else begin
            len = (r < 95) ? $urandom_range(1, 8) : $urandom_range(60, 70);
            w.delete();
            for (int i = 0; i < len; i++)
                w.push_back(rand_letter());
        end
        foreach (w[i])
            send_byte(w[i], rand_eot());
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
        int start;
        int r;
        start         = items_sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_sent - start < n_items) begin
            r = $urandom_range(99);
            if (r < 35)
                send_random_number();
            else if (r < 65)
                send_random_word();
            else if (r < 80)
                case ($urandom_range(2))
                    0:       send_byte(CH_OPEN, rand_eot());
                    1:       send_byte(CH_CLOSE, rand_eot());
                    default: send_byte(CH_SEMI, rand_eot());
                endcase
            else if (r < 90)
                send_byte(space_bytes[$urandom_range(5)], rand_eot());
            else
                send_byte(8'($urandom_range(255)), rand_eot());
            if ($urandom_range(1))
                send_byte(space_bytes[$urandom_range(5)], rand_eot());
        end
        stop_sending();
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        for (int i = 0; i < 40; i++)
            send_byte((i % 3 == 0) ? CH_OPEN : (i % 3 == 1) ? CH_CLOSE : CH_SEMI, 1'b0);
        stop_sending();
        wait_drain();
    endtask

    // token side: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles  = hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // the token transfer happens at the next rising edge; outputs are stable here
    always @(negedge i_clk) begin : token_monitor
        t_token want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d",
                         $time, o_token_kind);
                errors++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 64'(want.kind), 64'(o_token_kind));
                check_field("number_value", 64'(want.value), 64'(o_number_value));
                check_field("number_overflow", 64'(want.ovf), 64'(o_number_overflow));
                check_field("word_length", 64'(want.len), 64'(o_word_length));
                check_field("bad_byte", 64'(want.bad), 64'(o_bad_byte));
                check_field("last_of_run", 64'(want.last), 64'(o_last_of_run));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_text_byte   = '0;
        i_end_of_text = 1'b0;
        i_stall       = 1'b0;
        lex_run       = RUN_IDLE;
        lex_value     = '0;
        lex_sat       = 1'b0;
        lex_match     = MATCH_NONE;
        lex_letters   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 82;
        test_separators();
        test_keywords();
        test_numbers();
        stop_sending();
        wait_drain();

        test_random(550, 24, 82);
        test_random(550, 82, 24);
        test_backpressure();
        test_random(550, 0, 0);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
